>>> rtl/core/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int ADDR_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W      = 32;
    localparam int TAG_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // store: record goes into the sort memory; last: closes the set
    typedef struct packed {
        t_rec rec;
        logic store;
        logic last;
        logic ovf;
    } t_cmd;

    typedef enum logic [2:0] {
        S_LOAD,
        S_A_RD,
        S_A_CAP,
        S_B_RD,
        S_B_CMP,
        S_A_WB,
        S_EM_RD,
        S_EM_WAIT
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/core/rsd_front.sv
`default_nettype none

module rsd_front
    import rsd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [TAG_W-1:0] i_tag,
    input  wire logic             i_last,
    output logic                  o_full,
    input  wire logic             i_q_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             accept;
    logic             room;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign room   = (r_count != CNT_W'(MAX_ITEMS));

    // dropped non-last beats only set the flag; nothing goes to the back end
    assign o_cmd_push    = accept && (room || i_last);
    assign o_cmd.rec.key = i_key;
    assign o_cmd.rec.tag = i_tag;
    assign o_cmd.store   = room;
    assign o_cmd.last    = i_last;
    assign o_cmd.ovf     = r_ovf || !room;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (accept) begin
            if (i_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (room) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rsd_cmd_fifo.sv
`default_nettype none

module rsd_cmd_fifo
    import rsd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_data
);

    t_cmd                  r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                  do_push, do_pop;

    assign o_full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + FIFO_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rsd_back.sv
`default_nettype none

module rsd_back
    import rsd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire t_cmd             i_cmd,
    output logic                  o_q_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic [KEY_W-1:0]      o_key,
    output logic [TAG_W-1:0]      o_tag,
    output logic                  o_last,
    output logic                  o_ovf
);

    t_rec              mem [MAX_ITEMS];
    t_rec              r_rd_data;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    t_rec              wr_data;

    t_back_state       r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_a, n_a;
    logic [ADDR_W-1:0] r_b, n_b;
    logic [ADDR_W-1:0] r_k, n_k;
    t_rec              r_hold, n_hold;
    logic              r_ovf, n_ovf;

    logic              r_out_valid, n_out_valid;
    t_rec              r_out, n_out;
    logic              r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;

    logic [CNT_W-1:0]  final_n;

    assign o_empty = !r_out_valid;
    assign o_key   = r_out.key;
    assign o_tag   = r_out.tag;
    assign o_last  = r_out_last;
    assign o_ovf   = r_out_ovf;

    assign final_n = r_n + CNT_W'(i_cmd.store);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_hold      = r_hold;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_a;
        wr_en       = 1'b0;
        wr_addr     = r_a;
        wr_data     = r_hold;

        unique case (r_state)
            S_LOAD: begin
                o_q_pop = !i_q_empty;
                if (!i_q_empty) begin
                    if (i_cmd.store) begin
                        wr_en   = 1'b1;
                        wr_addr = r_n[ADDR_W-1:0];
                        wr_data = i_cmd.rec;
                        n_n     = final_n;
                    end
                    if (i_cmd.last) begin
                        n_ovf = i_cmd.ovf;
                        n_a   = '0;
                        n_k   = '0;
                        n_state = (final_n > CNT_W'(1)) ? S_A_RD : S_EM_RD;
                    end
                end
            end
            S_A_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_a;
                n_state = S_A_CAP;
            end
            S_A_CAP: begin
                n_hold  = r_rd_data;
                n_b     = r_a + ADDR_W'(1);
                n_state = S_B_RD;
            end
            S_B_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_b;
                n_state = S_B_CMP;
            end
            S_B_CMP: begin
                // position a's record lives in r_hold during its inner pass
                if (r_hold.key < r_rd_data.key) begin
                    wr_en   = 1'b1;
                    wr_addr = r_b;
                    wr_data = r_hold;
                    n_hold  = r_rd_data;
                end
                if (CNT_W'(r_b) + CNT_W'(1) == r_n) begin
                    n_state = S_A_WB;
                end else begin
                    n_b     = r_b + ADDR_W'(1);
                    n_state = S_B_RD;
                end
            end
            S_A_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_a;
                wr_data = r_hold;
                if (CNT_W'(r_a) + CNT_W'(2) == r_n) begin
                    n_k     = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_a     = r_a + ADDR_W'(1);
                    n_state = S_A_RD;
                end
            end
            S_EM_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k;
                n_state = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out       = r_rd_data;
                    n_out_ovf   = r_ovf;
                    n_out_last  = (CNT_W'(r_k) + CNT_W'(1) == r_n);
                    if (CNT_W'(r_k) + CNT_W'(1) == r_n) begin
                        n_n     = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + ADDR_W'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

endmodule

`default_nettype wire

>>> rtl/core/record_sort_descending_unit.sv
// Channel   Handshake     Beat fields
// input     push / full   i_size_key, i_record_tag, i_last_item
// result    pop / empty   o_sorted_key, o_sorted_tag, o_last_result, o_overflowed
//
// Records load at one beat per cycle while full is low into a 4-deep command
// queue; the back end drains it into the sort memory at one record per cycle in
// its load state. After the last beat the exchange sort runs on the single-port
// memory: an outer position reads, captures, writes back; a compare reads, may
// swap. Results leave by a memory read, then the output register, held while
// pop is low. Reset (synchronous, active low) empties the queue and sets.
`default_nettype none

module record_sort_descending_unit
    import rsd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [KEY_W-1:0] i_size_key,
    input  wire logic [TAG_W-1:0] i_record_tag,
    input  wire logic             i_last_item,
    output logic                  empty,
    input  wire logic             pop,
    output logic [KEY_W-1:0]      o_sorted_key,
    output logic [TAG_W-1:0]      o_sorted_tag,
    output logic                  o_last_result,
    output logic                  o_overflowed
);

    logic cmd_push, q_full, q_empty, q_pop;
    t_cmd cmd_in, cmd_out;

    rsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_key      (i_size_key),
        .i_tag      (i_record_tag),
        .i_last     (i_last_item),
        .o_full     (full),
        .i_q_full   (q_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rsd_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (cmd_out)
    );

    rsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (cmd_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_key     (o_sorted_key),
        .o_tag     (o_sorted_tag),
        .o_last    (o_last_result),
        .o_ovf     (o_overflowed)
    );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rsd_pkg::*;

    localparam int N_ITEMS     = 220;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGE
    } t_key_mix;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             ovf;
    } t_sorted_beat;

    class sort_scoreboard;
        logic [KEY_W-1:0] key_mem [MAX_ITEMS];
        logic [TAG_W-1:0] tag_mem [MAX_ITEMS];
        int               n_stored   = 0;
        bit               dropped    = 1'b0;
        t_sorted_beat     sorted_q [$];
        int               mismatches = 0;
        int               n_checked  = 0;

        task report_mismatch(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Store the record; on the closing beat run the exchange sort and queue the run.
        function void note_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                                  input logic last);
            t_sorted_beat     beat;
            logic [KEY_W-1:0] hold_key;
            logic [TAG_W-1:0] hold_tag;
            if (n_stored < MAX_ITEMS) begin
                key_mem[n_stored] = key;
                tag_mem[n_stored] = tag;
                n_stored++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;
            for (int a = 0; a + 1 < n_stored; a++) begin
                for (int b = a + 1; b < n_stored; b++) begin
                    if (key_mem[a] < key_mem[b]) begin
                        hold_key   = key_mem[a];
                        hold_tag   = tag_mem[a];
                        key_mem[a] = key_mem[b];
                        tag_mem[a] = tag_mem[b];
                        key_mem[b] = hold_key;
                        tag_mem[b] = hold_tag;
                    end
                end
            end
            for (int k = 0; k < n_stored; k++) begin
                beat.key  = key_mem[k];
                beat.tag  = tag_mem[k];
                beat.last = (k == n_stored - 1);
                beat.ovf  = dropped;
                sorted_q.push_back(beat);
            end
            n_stored = 0;
            dropped  = 1'b0;
        endfunction

        task check_result(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                          input logic last, input logic ovf);
            t_sorted_beat want;
            n_checked++;
            if (sorted_q.size() == 0) begin
                report_mismatch($sformatf("beat %0d: no result pending (key %h tag %0d)",
                                          n_checked, key, tag));
                return;
            end
            want = sorted_q.pop_front();
            if (key !== want.key)
                report_mismatch($sformatf("beat %0d sorted_key: got %h want %h",
                                          n_checked, key, want.key));
            if (tag !== want.tag)
                report_mismatch($sformatf("beat %0d sorted_tag: got %0d want %0d",
                                          n_checked, tag, want.tag));
            if (last !== want.last)
                report_mismatch($sformatf("beat %0d last_result: got %b want %b",
                                          n_checked, last, want.last));
            if (ovf !== want.ovf)
                report_mismatch($sformatf("beat %0d overflowed: got %b want %b",
                                          n_checked, ovf, want.ovf));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic push;
    logic full;
    logic [KEY_W-1:0] i_size_key;
    logic [TAG_W-1:0] i_record_tag;
    logic i_last_item;
    logic empty;
    logic pop;
    logic [KEY_W-1:0] o_sorted_key;
    logic [TAG_W-1:0] o_sorted_tag;
    logic o_last_result;
    logic o_overflowed;

    sort_scoreboard sb = new();

    int n_sent        = 0;
    bit random_phase  = 1'b0;
    bit no_idle       = 1'b0;
    bit full_set_done = 1'b0;
    bit overflow_done = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    record_sort_descending_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_size_key    (i_size_key),
        .i_record_tag  (i_record_tag),
        .i_last_item   (i_last_item),
        .empty         (empty),
        .pop           (pop),
        .o_sorted_key  (o_sorted_key),
        .o_sorted_tag  (o_sorted_tag),
        .o_last_result (o_last_result),
        .o_overflowed  (o_overflowed)
    );

    function automatic logic [KEY_W-1:0] rand_key(input t_key_mix mix);
        case (mix)
            MIX_WIDE:   return KEY_W'($urandom);
            MIX_NARROW: return KEY_W'($urandom_range(7));   // lots of equal keys
            default: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return '1;
                    2:       return {1'b1, {(KEY_W-1){1'b0}}};
                    3:       return {1'b0, {(KEY_W-1){1'b1}}};
                    default: return KEY_W'($urandom);
                endcase
            end
        endcase
    endfunction

    // Leaves push high after the accepting edge; a drain lowers it, the next call only for idle gaps.
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
        no_idle = random_phase && n_sent >= 90 && n_sent < 150;
        while (!no_idle && $urandom_range(99) < 37) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_size_key   <= key;
        i_record_tag <= tag;
        i_last_item  <= last;
        do @(posedge i_clk); while (full);
        sb.note_record(key, tag, last);
        n_sent++;
    endtask

    task automatic send_fixed(input logic [KEY_W-1:0] keys [$], input int tag_base);
        for (int k = 0; k < keys.size(); k++)
            send_record(keys[k], TAG_W'(tag_base + k), k == keys.size() - 1);
    endtask

    task automatic send_set(input int size, input t_key_mix mix);
        for (int k = 0; k < size; k++)
            send_record(rand_key(mix), TAG_W'($urandom_range(63)), k == size - 1);
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (sb.sorted_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_size_key   = '0;
        i_record_tag = '0;
        i_last_item  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-record runs at the key and tag extremes
        send_fixed('{32'hFFFF_FFFF}, 63);
        send_fixed('{32'h0}, 0);
        // duplicates mixed with extremes: tie order follows the exchange procedure
        send_fixed('{32'd5, 32'hA, 32'd5, 32'hFFFF_FFFF, 32'h0, 32'hA, 32'd5}, 1);
        send_fixed('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 10);
        // ascending input, then already descending
        send_fixed('{32'd1, 32'd2, 32'd3, 32'd4}, 40);
        send_fixed('{32'd9, 32'd7, 32'd3}, 60);
        wait_drain();

        random_phase = 1'b1;
        while (n_sent < N_ITEMS || !full_set_done || !overflow_done) begin
            if (!full_set_done && n_sent >= 60) begin
                send_set(MAX_ITEMS, MIX_WIDE);
                full_set_done = 1'b1;
                wait_drain();
            end else if (!overflow_done && n_sent >= 120) begin
                // two beats past capacity; the closing beat itself is dropped
                send_set(MAX_ITEMS + 2, t_key_mix'($urandom_range(2)));
                overflow_done = 1'b1;
            end else if ($urandom_range(9) == 0) begin
                send_set($urandom_range(9, 20), t_key_mix'($urandom_range(2)));
            end else begin
                send_set($urandom_range(1, 8), t_key_mix'($urandom_range(2)));
            end
        end
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.sorted_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side: random pop, plus one long hold so the input queue backs up
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                sb.check_result(o_sorted_key, o_sorted_tag, o_last_result, o_overflowed);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (!hold_done && random_phase && sb.n_checked >= 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(99) >= 37);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
